### design/mkdt_pkg.sv
// Shared types, widths and time-compare helpers for the double tap detector.
// No dependencies; every other design file imports this package.
package mkdt_pkg;

  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned FRAME_W   = 16;
  localparam int unsigned WIN_W     = 17;
  localparam int unsigned KEY_W     = 5;
  localparam int unsigned TAP_W     = 3;
  localparam int unsigned LANES_DEF = 5;

  localparam logic [CFG_W-1:0] TAP_WINDOW_RST = 16'd100;

  typedef struct packed {
    logic upd;
    logic clr;
    logic down;
  } lane_ctl_t;

  // Wrapped age read as signed: negative ages count as inside the window.
  function automatic logic age_below(logic [STAMP_W-1:0] age, logic [WIN_W-1:0] win);
    return age[STAMP_W-1] || (age < {{(STAMP_W-WIN_W){1'b0}}, win});
  endfunction

  function automatic logic age_above(logic [STAMP_W-1:0] age, logic [WIN_W-1:0] win);
    return !age[STAMP_W-1] && (age > {{(STAMP_W-WIN_W){1'b0}}, win});
  endfunction

endpackage

### design/multi_key_double_tap_detector_top.sv
// Top level of the multi-key double tap detector: lanes, newest-stamp
// select and tap merge. Depends on mkdt_pkg, mkdt_lane, mkdt_select, mkdt_merge.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per frame tick:
//   now_time_i, frame_time_i and key_down_i. Output channel
//   (out_valid_o / out_stall_i) returns one word per input word with
//   double_tap_o: 0 for none, else the highest direction that completed a
//   press, release, press-again sequence inside tap_window + frame_time.
//   cfg_we_i / cfg_wdata_i write tap_window; write only while idle.
//   The result is valid in the cycle after the input word is accepted.
//   Throughput: one word per cycle unless the receiver stalls; all lanes and
//   newest-stamp compare finish on accept, so the next word can follow at once.
//   Reset clears all stamps and the last tap time and sets tap_window to 100.
//   While the receiver stalls, the result register holds and in_stall_o is
//   raised; an input word is still taken in any cycle the result register
//   is empty or being drained.
module multi_key_double_tap_detector_top import mkdt_pkg::*; #(
  parameter int unsigned LANES = LANES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [STAMP_W-1:0] now_time_i,
  input  logic [FRAME_W-1:0] frame_time_i,
  input  logic [KEY_W-1:0]   key_down_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [TAP_W-1:0]   double_tap_o
);

  logic [CFG_W-1:0]              tap_window_q;
  logic [STAMP_W-1:0]            last_tap_q;
  logic [WIN_W-1:0]              win;
  logic                          in_acc, gate, any_newest;
  logic [LANES-1:0][STAMP_W-1:0] stamps;
  logic [LANES-1:0]              newest, taps;
  lane_ctl_t                     ctl [LANES];

  assign in_stall_o = out_valid_o && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign win        = {1'b0, tap_window_q} + {1'b0, frame_time_i};
  assign gate       = (last_tap_q == '0) || age_above(now_time_i - last_tap_q, win);
  assign any_newest = |newest;

  mkdt_select #(.LANES(LANES)) u_select (
    .stamp_i (stamps),
    .newest_o(newest)
  );

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic down;
    if (k < KEY_W) begin : g_key
      assign down = key_down_i[k];
    end else begin : g_nokey
      assign down = 1'b0;
    end

    assign ctl[k] = '{upd: in_acc && gate, clr: any_newest && !newest[k], down: down};

    mkdt_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[k]),
      .now_i  (now_time_i),
      .win_i  (win),
      .stamp_o(stamps[k]),
      .tap_o  (taps[k])
    );
  end

  mkdt_merge #(.LANES(LANES)) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .tap_i       (taps),
    .stall_i     (out_stall_i),
    .valid_o     (out_valid_o),
    .double_tap_o(double_tap_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_window_q <= TAP_WINDOW_RST;
      last_tap_q   <= '0;
    end else begin
      if (cfg_we_i) tap_window_q <= cfg_wdata_i;
      if (|taps) last_tap_q <= now_time_i;
    end
  end

  a_newest_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(newest))
    else $error("more than one lane selected as newest");

  a_last_tap_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|taps) |=> last_tap_q == $past(now_time_i))
    else $error("last tap time not taken from the tapping word");

  a_tap_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|taps) |-> in_acc && gate)
    else $error("lane tap outside an enabled accept");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted word produced no result");

endmodule

### design/mkdt_lane.sv
// One direction lane: press and release stamps plus the press, release,
// press-again rule. Depends on mkdt_pkg.
module mkdt_lane import mkdt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lane_ctl_t          ctl_i,
  input  logic [STAMP_W-1:0] now_i,
  input  logic [WIN_W-1:0]   win_i,
  output logic [STAMP_W-1:0] stamp_o,
  output logic               tap_o
);

  logic [STAMP_W-1:0] press_q, press_d, rel_q, rel_d;
  logic [STAMP_W-1:0] p, r;
  logic               p_set, r_set, p_young, r_young;

  // Newest of this lane's stamps; release must be strictly newer to win.
  assign stamp_o = (rel_q > press_q) ? rel_q : press_q;

  always_comb begin
    p       = ctl_i.clr ? '0 : press_q;
    r       = ctl_i.clr ? '0 : rel_q;
    p_set   = |p;
    r_set   = |r;
    p_young = age_below(now_i - p, win_i);
    r_young = age_below(now_i - r, win_i);
    press_d = p;
    rel_d   = r;
    tap_o   = 1'b0;
    if (ctl_i.down && !p_set) begin
      press_d = now_i;
    end else if (!ctl_i.down && p_set && !r_set && p_young) begin
      rel_d = now_i;
    end else if (ctl_i.down && p_set && r_set && p_young && r_young) begin
      press_d = '0;
      rel_d   = '0;
      tap_o   = ctl_i.upd;
    end else if (!ctl_i.down && (p_set || r_set) && !p_young) begin
      press_d = '0;
      rel_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q <= '0;
      rel_q   <= '0;
    end else if (ctl_i.upd) begin
      press_q <= press_d;
      rel_q   <= rel_d;
    end
  end

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_i.upd |=> $stable(press_q) && $stable(rel_q))
    else $error("lane stamps changed without an update");

  a_tap_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tap_o |=> press_q == '0 && rel_q == '0)
    else $error("lane kept stamps after a double tap");

endmodule

### design/mkdt_select.sv
// Newest-stamp selection across lanes: one-hot mark of the lane that keeps
// its stamps, lower lane wins a tie. Depends on mkdt_pkg.
module mkdt_select import mkdt_pkg::*; #(
  parameter int unsigned LANES = LANES_DEF
) (
  input  logic [LANES-1:0][STAMP_W-1:0] stamp_i,
  output logic [LANES-1:0]              newest_o
);

  // Each lane compares against all others in parallel.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      newest_o[k] = |stamp_i[k];
      for (int j = 0; j < LANES; j++) begin
        if (j < k) begin
          if (!(stamp_i[k] > stamp_i[j])) newest_o[k] = 1'b0;
        end else if (j > k) begin
          if (stamp_i[k] < stamp_i[j]) newest_o[k] = 1'b0;
        end
      end
    end
  end

endmodule

### design/mkdt_merge.sv
// Merge of lane taps into the reported direction, held in the output
// register of the result channel. Depends on mkdt_pkg.
module mkdt_merge import mkdt_pkg::*; #(
  parameter int unsigned LANES = LANES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [LANES-1:0] tap_i,
  input  logic             stall_i,
  output logic             valid_o,
  output logic [TAP_W-1:0] double_tap_o
);

  localparam int unsigned IDX_W = ($clog2(LANES + 1) > TAP_W) ? $clog2(LANES + 1) : TAP_W;

  logic [IDX_W-1:0] idx;
  logic             valid_q, valid_d;
  logic [TAP_W-1:0] tap_q;

  // Highest tapping direction wins.
  always_comb begin
    idx = '0;
    for (int k = 0; k < LANES; k++) begin
      if (tap_i[k]) idx = IDX_W'(k + 1);
    end
  end

  assign valid_d = accept_i || (valid_q && stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      tap_q <= idx[TAP_W-1:0];
    end
  end

  assign valid_o      = valid_q;
  assign double_tap_o = tap_q;

endmodule

### dv/tb_multi_key_double_tap_detector_top.sv
`timescale 1ns / 100ps
// Self-checking bench for multi_key_double_tap_detector_top: directed taps per direction,
// then random tick streams under several tap_window settings. Uses mkdt_pkg and the design.

module tb_multi_key_double_tap_detector_top;
  import mkdt_pkg::*;

  typedef enum logic [TAP_W-1:0] {
    TAP_NONE, TAP_LEFT, TAP_RIGHT, TAP_FORWARD, TAP_BACK, TAP_UP
  } tap_dir_e;

  class tap_scoreboard;
    logic [CFG_W-1:0]   tap_window;
    logic [STAMP_W-1:0] press_t [LANES_DEF];
    logic [STAMP_W-1:0] release_t [LANES_DEF];
    logic [STAMP_W-1:0] last_tap_t;
    tap_dir_e           expected_taps [$];
    int                 errors;

    function new();
      tap_window = TAP_WINDOW_RST;
      foreach (press_t[k]) begin
        press_t[k]   = '0;
        release_t[k] = '0;
      end
      last_tap_t = '0;
      errors     = 0;
    endfunction

    // Wrapped age read as signed: a negative age still counts as fresh.
    function bit fresh(logic [STAMP_W-1:0] age, logic [STAMP_W-1:0] win);
      return age[STAMP_W-1] || age < win;
    endfunction

    function bit expired(logic [STAMP_W-1:0] age, logic [STAMP_W-1:0] win);
      return !age[STAMP_W-1] && age > win;
    endfunction

    function void note_word(logic [STAMP_W-1:0] now, logic [FRAME_W-1:0] frame,
                            logic [KEY_W-1:0] keys);
      logic [STAMP_W-1:0] win;
      logic [STAMP_W-1:0] p;
      logic [STAMP_W-1:0] r;
      logic [STAMP_W-1:0] newest_t;
      int                 newest;
      tap_dir_e           tap;
      win = STAMP_W'(tap_window) + STAMP_W'(frame);
      tap = TAP_NONE;
      if (last_tap_t == '0 || expired(now - last_tap_t, win)) begin
        newest   = -1;
        newest_t = '0;
        for (int k = 0; k < LANES_DEF; k++) begin
          if (press_t[k] > newest_t) begin
            newest_t = press_t[k];
            newest   = k;
          end
          if (release_t[k] > newest_t) begin
            newest_t = release_t[k];
            newest   = k;
          end
        end
        // keep only the most recently touched direction
        if (newest >= 0) begin
          for (int k = 0; k < LANES_DEF; k++) begin
            if (k != newest) begin
              press_t[k]   = '0;
              release_t[k] = '0;
            end
          end
        end
        for (int k = 0; k < LANES_DEF; k++) begin
          p = press_t[k];
          r = release_t[k];
          if (keys[k] && p == '0) begin
            press_t[k] = now;
          end else if (!keys[k] && p != '0 && r == '0 && fresh(now - p, win)) begin
            release_t[k] = now;
          end else if (keys[k] && p != '0 && r != '0 &&
                       fresh(now - p, win) && fresh(now - r, win)) begin
            press_t[k]   = '0;
            release_t[k] = '0;
            tap          = tap_dir_e'(k + 1);
            last_tap_t   = now;
          end else if (!keys[k] && (p != '0 || r != '0) && !fresh(now - p, win)) begin
            press_t[k]   = '0;
            release_t[k] = '0;
          end
        end
      end
      expected_taps.push_back(tap);
    endfunction

    function void check_tap(logic [TAP_W-1:0] got);
      tap_dir_e want;
      if (expected_taps.size() == 0) begin
        $display("%0t: double_tap expected none, got %0d", $time, got);
        errors++;
        return;
      end
      want = expected_taps.pop_front();
      if (got !== want) begin
        $display("%0t: double_tap expected %0d, got %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CFG_W-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [STAMP_W-1:0] now_time_i;
  logic [FRAME_W-1:0] frame_time_i;
  logic [KEY_W-1:0]   key_down_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [TAP_W-1:0]   double_tap_o;

  tap_scoreboard      sb = new();
  logic [STAMP_W-1:0] cur_t;
  int unsigned        sent;
  bit                 calm_in  = 1'b0;
  bit                 calm_out = 1'b0;

  multi_key_double_tap_detector_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .now_time_i   (now_time_i),
    .frame_time_i (frame_time_i),
    .key_down_i   (key_down_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .double_tap_o (double_tap_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Enter and leave at a falling edge.
  task automatic send_word(input logic [STAMP_W-1:0] now, input logic [FRAME_W-1:0] frame,
                           input logic [KEY_W-1:0] keys);
    int unsigned gap;
    if ($urandom_range(0, 63) == 0) calm_in = !calm_in;
    gap = calm_in ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    now_time_i   <= now;
    frame_time_i <= frame;
    key_down_i   <= keys;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(now, frame, keys);
    @(negedge clk_i);
  endtask

  task automatic tap_seq(input tap_dir_e d, input logic [STAMP_W-1:0] t,
                         input logic [STAMP_W-1:0] step, input logic [FRAME_W-1:0] frame);
    logic [KEY_W-1:0] base;
    base = KEY_W'(1) << (d - 1);
    send_word(t, frame, base);
    send_word(t + step, frame, '0);
    send_word(t + 2 * step, frame, base);
  endtask

  task automatic tick(input logic [STAMP_W-1:0] step, input logic [FRAME_W-1:0] frame,
                      input logic [KEY_W-1:0] keys);
    cur_t += step;
    send_word(cur_t, frame, keys);
    sent++;
  endtask

  // Hold the sender off until every word in flight has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_taps.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] w);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.tap_window = w;
  endtask

  // Gaps mostly inside the window, some well past it.
  function automatic int unsigned pace(int unsigned span);
    if ($urandom_range(0, 3) != 0) return $urandom_range(1, span);
    return $urandom_range(1, 3 * span);
  endfunction

  initial begin
    logic [CFG_W-1:0] windows [5];
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] extra;
    logic [FRAME_W-1:0] fr;
    int unsigned      span;
    int unsigned      pick;
    int               d;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    now_time_i   = '0;
    frame_time_i = '0;
    key_down_i   = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // one tap per direction near the top of the time range
    cur_t = 32'hFFFF_F000;
    for (int k = TAP_LEFT; k <= TAP_UP; k++) begin
      tap_seq(tap_dir_e'(k), cur_t, 32'd30, 16'd10);
      cur_t += 200;
    end
    // all keys at once: a tie keeps the lowest direction
    send_word(32'hFFFF_F600, 16'd0, 5'h1F);
    send_word(32'hFFFF_F610, 16'd0, 5'h00);
    send_word(32'hFFFF_F620, 16'd0, 5'h1F);
    // tap across the wrap, landing on time zero
    tap_seq(TAP_FORWARD, 32'hFFFF_FFC0, 32'h20, 16'd10);
    // a press at time zero reads as empty afterwards
    send_word(32'd0, 16'd10, 5'b00001);
    send_word(32'd5, 16'hFFFF, 5'b00001);
    send_word(32'd40, 16'hFFFF, 5'b00000);

    windows[0] = 16'd0;
    windows[1] = 16'hFFFF;
    windows[2] = 16'd20;
    windows[3] = CFG_W'($urandom_range(0, 16'hFFFF));
    windows[4] = 16'd250;
    foreach (windows[i]) begin
      drain();
      write_window(windows[i]);
      span = windows[i] + 40;
      sent = 0;
      while (sent < 300) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          d     = $urandom_range(0, LANES_DEF - 1);
          base  = KEY_W'(1) << d;
          fr    = FRAME_W'($urandom_range(0, 33));
          extra = ($urandom_range(0, 4) == 0) ? KEY_W'($urandom) & ~base : '0;
          repeat ($urandom_range(0, 2)) tick(pace(span), fr, extra);
          tick(pace(span), fr, base | extra);
          repeat ($urandom_range(0, 2)) tick(pace(span), fr, base | extra);
          tick(pace(span), fr, extra);
          if ($urandom_range(0, 3) == 0) tick(pace(span), fr, extra);
          tick(pace(span), fr, base | ($urandom_range(0, 1) ? extra : '0));
        end else if (pick < 95) begin
          tick($urandom_range(0, 2 * span), FRAME_W'($urandom_range(0, 40)),
               KEY_W'($urandom));
        end else begin
          // jump anywhere in time, mostly forward
          tick($urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h7FFF_FFFF),
               FRAME_W'($urandom), KEY_W'($urandom));
        end
        if ($urandom_range(0, 199) == 0) drain();
      end
    end

    drain();
    repeat (4) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("multi_key_double_tap_detector_top: match");
    end else begin
      $display("multi_key_double_tap_detector_top: mismatch");
    end
    $finish;
  end

  // Receiver: stall a random number of cycles before taking each word.
  initial begin
    int unsigned hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 63) == 0) calm_out = !calm_out;
      hold = calm_out ? 0 : $urandom_range(0, 4);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_tap(double_tap_o);
      @(negedge clk_i);
    end
  end

  initial begin
    #3_000_000;
    $display("multi_key_double_tap_detector_top: mismatch");
    $finish;
  end

endmodule
